// ----- rtl/core/cbts_pkg.sv -----
// Shared types and constants for the compass bus transaction sequencer.
// Holds the bus status codes, control codes and the result record.
// No dependencies.
package cbts_pkg;

  localparam int unsigned RECEIVE_DEPTH = 7;
  localparam int unsigned STORE_AW      = (RECEIVE_DEPTH > 1) ? $clog2(RECEIVE_DEPTH) : 1;

  localparam logic [7:0] EV_START     = 8'h08;
  localparam logic [7:0] EV_RESTART   = 8'h10;
  localparam logic [7:0] EV_SLA_W_ACK = 8'h18;
  localparam logic [7:0] EV_DATA_ACK  = 8'h28;
  localparam logic [7:0] EV_DATA_NACK = 8'h30;
  localparam logic [7:0] EV_SLA_R_ACK = 8'h40;
  localparam logic [7:0] EV_RX_ACK    = 8'h50;
  localparam logic [7:0] EV_RX_NACK   = 8'h58;

  localparam logic [7:0] ADDR_RAW = 8'h3D;
  localparam logic [7:0] ADDR_HPR = 8'h33;

  localparam logic [1:0] ACK_KEEP = 2'd0;
  localparam logic [1:0] ACK_ACK  = 2'd1;
  localparam logic [1:0] ACK_NACK = 2'd2;

  localparam logic [1:0] FRAME_NONE    = 2'd0;
  localparam logic [1:0] FRAME_RAW     = 2'd1;
  localparam logic [1:0] FRAME_HPR     = 2'd2;
  localparam logic [1:0] FRAME_UNKNOWN = 2'd3;

  localparam logic [2:0] REG_ADDRESS   = 3'd0;
  localparam logic [2:0] REG_WR_COUNT  = 3'd1;
  localparam logic [2:0] REG_FIRST_TX  = 3'd2;
  localparam logic [2:0] REG_SECOND_TX = 3'd3;
  localparam logic [2:0] REG_RD_COUNT  = 3'd4;

  // tx_valid in the lowest bit
  typedef struct packed {
    logic signed [15:0] value_third;
    logic signed [15:0] value_second;
    logic signed [15:0] value_first;
    logic [1:0]         ack_control;
    logic               stop_request;
    logic               clear_start;
    logic [7:0]         tx_byte;
    logic               tx_valid;
  } result_t;

endpackage

// ----- rtl/core/compass_bus_transaction_sequencer.sv -----
// Compass bus transaction sequencer: one status event in, one controller command out.
// Depends on cbts_pkg for status codes, control codes and the result record.
//
// Usage:
//   s_axis: one bus status event per transfer, tuser = command, tdata = received byte.
//   m_axis: one result per event; tdata carries the controller command and the
//     decoded values, tuser carries the frame kind.
//   APB: five registers at byte addresses 0x00..0x10, to be written by the user
//   only while the block is idle; the block itself does not enforce this.
// Pipeline: input register, then result register. Throughput: one event per cycle
//   while m_axis_tready holds high; the sequencing state (write/read positions,
//   receive store) updates in the same cycle an event moves from the input
//   register to the result register.
// Reset: positions clear to zero, registers take 0, 1, 0, 0, 6; the receive
//   store is left as is.
// Stall: while m_axis_tready is low a waiting result holds, the input register
//   holds behind it and s_axis_tready drops once both are full.
module compass_bus_transaction_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] received_byte
  input  logic [7:0]  s_axis_tuser,   // [7:0] command
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] clear_start, [10] stop_request,
  // [12:11] ack_control, [28:13] value_first, [44:29] value_second,
  // [60:45] value_third, [63:61] zero
  output logic [63:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // [1:0] frame_kind
);

  logic [7:0] address_byte_q;
  logic [1:0] write_count_q;
  logic [7:0] first_tx_byte_q;
  logic [7:0] second_tx_byte_q;
  logic [2:0] read_count_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  logic       in_valid_q;
  logic [7:0] cmd_q;
  logic [7:0] rx_q;
  logic       out_valid_q;
  cbts_pkg::result_t res_q, res_d;
  logic [1:0] kind_q, kind_d;

  logic [1:0] wr_pos_q, wr_pos_d;
  logic [2:0] rd_pos_q, rd_pos_d;
  logic [7:0] store_q [cbts_pkg::RECEIVE_DEPTH];
  logic       store_we;
  logic [7:0] store_rd [6];

  logic       out_free;
  logic       advance;
  logic [3:0] count;
  logic [7:0] next_tx;
  logic       decoding;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_byte_q   <= 8'd0;
      write_count_q    <= 2'd1;
      first_tx_byte_q  <= 8'd0;
      second_tx_byte_q <= 8'd0;
      read_count_q     <= 3'd6;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cbts_pkg::REG_ADDRESS:   address_byte_q   <= pwdata[7:0];
        cbts_pkg::REG_WR_COUNT:  write_count_q    <= pwdata[1:0];
        cbts_pkg::REG_FIRST_TX:  first_tx_byte_q  <= pwdata[7:0];
        cbts_pkg::REG_SECOND_TX: second_tx_byte_q <= pwdata[7:0];
        cbts_pkg::REG_RD_COUNT:  read_count_q     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (cfg_idx)
      cbts_pkg::REG_ADDRESS:   prdata = {24'd0, address_byte_q};
      cbts_pkg::REG_WR_COUNT:  prdata = {30'd0, write_count_q};
      cbts_pkg::REG_FIRST_TX:  prdata = {24'd0, first_tx_byte_q};
      cbts_pkg::REG_SECOND_TX: prdata = {24'd0, second_tx_byte_q};
      cbts_pkg::REG_RD_COUNT:  prdata = {29'd0, read_count_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wr_pos_q    <= 2'd0;
      rd_pos_q    <= 3'd0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        wr_pos_q <= wr_pos_d;
        rd_pos_q <= rd_pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q <= s_axis_tuser;
      rx_q  <= s_axis_tdata;
    end
    if (advance) begin
      res_q  <= res_d;
      kind_q <= kind_d;
    end
    if (advance && store_we) begin
      store_q[rd_pos_q[cbts_pkg::STORE_AW-1:0]] <= rx_q;
    end
  end

  assign store_we = (cmd_q == cbts_pkg::EV_RX_ACK || cmd_q == cbts_pkg::EV_RX_NACK) &&
                    ({1'b0, rd_pos_q} < 4'(cbts_pkg::RECEIVE_DEPTH));

  // store read with the byte of this event forwarded
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      store_rd[i] = (store_we && (rd_pos_q == 3'(i))) ? rx_q : store_q[i];
    end
  end

  assign count    = {1'b0, rd_pos_q} + 4'd1;
  assign decoding = count > {1'b0, read_count_q};

  always_comb begin
    unique case (wr_pos_q)
      2'd0:    next_tx = first_tx_byte_q;
      2'd1:    next_tx = second_tx_byte_q;
      default: next_tx = 8'd0;
    endcase
  end

  always_comb begin
    res_d    = '0;
    kind_d   = cbts_pkg::FRAME_NONE;
    wr_pos_d = wr_pos_q;
    rd_pos_d = rd_pos_q;
    unique case (cmd_q) inside
      cbts_pkg::EV_START: begin
        res_d.tx_valid    = 1'b1;
        res_d.tx_byte     = address_byte_q;
        res_d.clear_start = 1'b1;
      end
      cbts_pkg::EV_RESTART: begin
        res_d.clear_start = 1'b1;
      end
      cbts_pkg::EV_SLA_W_ACK: begin
        res_d.tx_valid = 1'b1;
        res_d.tx_byte  = next_tx;
        wr_pos_d       = wr_pos_q + 2'd1;
      end
      cbts_pkg::EV_DATA_ACK, cbts_pkg::EV_DATA_NACK: begin
        if (wr_pos_q != write_count_q) begin
          res_d.tx_valid = 1'b1;
          res_d.tx_byte  = next_tx;
          wr_pos_d       = wr_pos_q + 2'd1;
        end else begin
          res_d.stop_request = 1'b1;
        end
      end
      cbts_pkg::EV_SLA_R_ACK: begin
        res_d.ack_control = cbts_pkg::ACK_ACK;
      end
      cbts_pkg::EV_RX_ACK, cbts_pkg::EV_RX_NACK: begin
        if (!decoding) begin
          res_d.ack_control = (count == {1'b0, read_count_q}) ? cbts_pkg::ACK_NACK
                                                              : cbts_pkg::ACK_ACK;
          rd_pos_d = count[2:0];
        end else begin
          if (address_byte_q == cbts_pkg::ADDR_RAW || address_byte_q == cbts_pkg::ADDR_HPR) begin
            kind_d = (address_byte_q == cbts_pkg::ADDR_RAW) ? cbts_pkg::FRAME_RAW
                                                            : cbts_pkg::FRAME_HPR;
            res_d.value_first  = {store_rd[0], store_rd[1]};
            res_d.value_second = {store_rd[2], store_rd[3]};
            res_d.value_third  = {store_rd[4], store_rd[5]};
          end else begin
            kind_d = cbts_pkg::FRAME_UNKNOWN;
          end
          res_d.stop_request = 1'b1;
          rd_pos_d           = 3'd0;
          wr_pos_d           = 2'd0;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, res_q};
  assign m_axis_tuser  = kind_q;

  a_result_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_valid_q))
    else $error("result appeared without a held input");

  a_frame_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != cbts_pkg::FRAME_NONE) |-> res_q.stop_request)
    else $error("frame delivered without stop request");

  a_no_values_without_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == cbts_pkg::FRAME_NONE ||
                       m_axis_tuser == cbts_pkg::FRAME_UNKNOWN))
      |-> (res_q.value_first == 16'sd0 && res_q.value_second == 16'sd0 &&
           res_q.value_third == 16'sd0))
    else $error("decoded values present without a known frame");

  a_decode_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && store_we && decoding) |=> (rd_pos_q == 3'd0 && wr_pos_q == 2'd0))
    else $error("positions not cleared after decode");

endmodule

// ----- sim/compass_bus_transaction_sequencer_tb.sv -----
// Testbench for compass_bus_transaction_sequencer: bus status events in, controller commands
// out, each result checked field by field against a cycle-free model of the sequencing state
// or against fields set in the plan. Depends on cbts_pkg and the RTL of the sequencer only.
module compass_bus_transaction_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] address;
    logic [1:0] wr_count;
    logic [7:0] first_tx;
    logic [7:0] second_tx;
    logic [2:0] rd_count;
  } settings_t;

  typedef struct packed {
    logic [1:0]        frame_kind;
    cbts_pkg::result_t res;
  } response_t;

  typedef struct packed {
    logic       is_setup;
    logic       typed;
    logic [7:0] command;
    logic [7:0] rx_byte;
    response_t  want;
    settings_t  cfg;
  } plan_row_t;

  localparam int unsigned ITEMS_PER_SEGMENT = 70;
  localparam int unsigned SEGMENTS          = 9;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [7:0] received_byte
  logic [7:0]  s_axis_tuser  = '0;  // [7:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] tx_valid, [8:1] tx_byte, [9] clear_start, [10] stop_request, [12:11] ack_control,
  // [28:13] value_first, [44:29] value_second, [60:45] value_third
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;        // [1:0] frame_kind

  settings_t  cfg_now;
  logic [1:0] wr_pos;
  logic [2:0] rd_pos;
  logic [7:0] rx_store [cbts_pkg::RECEIVE_DEPTH];
  response_t  pending_responses[$];

  int failures       = 0;
  int bus_events     = 0;
  int responses_seen = 0;
  int frames_seen    = 0;
  int setups_done    = 0;
  int send_idle_pct  = 0;
  int ready_idle_pct = 0;

  compass_bus_transaction_sequencer uut (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] take_tx_byte();
    logic [7:0] b;
    b = (wr_pos == 2'd0) ? cfg_now.first_tx :
        (wr_pos == 2'd1) ? cfg_now.second_tx : 8'h00;
    wr_pos = wr_pos + 2'd1;
    return b;
  endfunction

  function automatic response_t sequencer_response(input logic [7:0] command,
                                                   input logic [7:0] rx_byte);
    response_t  r;
    logic [3:0] count;
    r = '0;
    case (command) inside
      cbts_pkg::EV_START: begin
        r.res.tx_valid    = 1'b1;
        r.res.tx_byte     = cfg_now.address;
        r.res.clear_start = 1'b1;
      end
      cbts_pkg::EV_RESTART: r.res.clear_start = 1'b1;
      cbts_pkg::EV_SLA_W_ACK: begin
        r.res.tx_valid = 1'b1;
        r.res.tx_byte  = take_tx_byte();
      end
      cbts_pkg::EV_DATA_ACK, cbts_pkg::EV_DATA_NACK: begin
        if (wr_pos != cfg_now.wr_count) begin
          r.res.tx_valid = 1'b1;
          r.res.tx_byte  = take_tx_byte();
        end else begin
          r.res.stop_request = 1'b1;
        end
      end
      cbts_pkg::EV_SLA_R_ACK: r.res.ack_control = cbts_pkg::ACK_ACK;
      cbts_pkg::EV_RX_ACK, cbts_pkg::EV_RX_NACK: begin
        if (rd_pos < cbts_pkg::RECEIVE_DEPTH) rx_store[rd_pos] = rx_byte;
        count = {1'b0, rd_pos} + 4'd1;
        if (count <= {1'b0, cfg_now.rd_count}) begin
          r.res.ack_control = (count == {1'b0, cfg_now.rd_count}) ? cbts_pkg::ACK_NACK
                                                                  : cbts_pkg::ACK_ACK;
          rd_pos = count[2:0];
        end else begin
          if (cfg_now.address == cbts_pkg::ADDR_RAW || cfg_now.address == cbts_pkg::ADDR_HPR) begin
            r.frame_kind       = (cfg_now.address == cbts_pkg::ADDR_RAW) ? cbts_pkg::FRAME_RAW
                                                                         : cbts_pkg::FRAME_HPR;
            r.res.value_first  = {rx_store[0], rx_store[1]};
            r.res.value_second = {rx_store[2], rx_store[3]};
            r.res.value_third  = {rx_store[4], rx_store[5]};
          end else begin
            r.frame_kind = cbts_pkg::FRAME_UNKNOWN;
          end
          r.res.stop_request = 1'b1;
          rd_pos = '0;
          wr_pos = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      failures++;
    end
  endfunction

  function automatic plan_row_t event_row(input logic [7:0] command, input logic [7:0] rx_byte);
    plan_row_t row;
    row = '0;
    row.command = command;
    row.rx_byte = rx_byte;
    return row;
  endfunction

  function automatic plan_row_t checked_row(input logic [7:0] command, input logic [7:0] rx_byte,
                                            input logic tx_valid, input logic [7:0] tx_byte,
                                            input logic clear_start, input logic stop_request,
                                            input logic [1:0] ack_control);
    plan_row_t row;
    row = event_row(command, rx_byte);
    row.typed                 = 1'b1;
    row.want.res.tx_valid     = tx_valid;
    row.want.res.tx_byte      = tx_byte;
    row.want.res.clear_start  = clear_start;
    row.want.res.stop_request = stop_request;
    row.want.res.ack_control  = ack_control;
    return row;
  endfunction

  function automatic plan_row_t setup_row(input logic [7:0] address, input logic [1:0] wr_count,
                                          input logic [7:0] first_tx, input logic [7:0] second_tx,
                                          input logic [2:0] rd_count);
    plan_row_t row;
    row = '0;
    row.is_setup = 1'b1;
    row.cfg      = '{address, wr_count, first_tx, second_tx, rd_count};
    return row;
  endfunction

  task automatic send_event(input logic [7:0] command, input logic [7:0] rx_byte,
                            input logic typed, input response_t typed_want);
    response_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= command;
    s_axis_tdata  <= rx_byte;
    do @(posedge clk_i); while (!s_axis_tready);
    want = sequencer_response(command, rx_byte);
    pending_responses.push_back(typed ? typed_want : want);
    if (command inside {cbts_pkg::EV_START, cbts_pkg::EV_RESTART, cbts_pkg::EV_SLA_W_ACK,
                        cbts_pkg::EV_DATA_ACK, cbts_pkg::EV_DATA_NACK, cbts_pkg::EV_SLA_R_ACK,
                        cbts_pkg::EV_RX_ACK, cbts_pkg::EV_RX_NACK})
      bus_events++;
  endtask

  // Drop an occasional step to break the sequence.
  task automatic send_step(input logic [7:0] command);
    if ($urandom_range(99) >= 6) send_event(command, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  task automatic drain_responses();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic apply_settings(input settings_t s);
    drain_responses();
    write_reg(cbts_pkg::REG_ADDRESS, 32'(s.address));
    write_reg(cbts_pkg::REG_WR_COUNT, 32'(s.wr_count));
    write_reg(cbts_pkg::REG_FIRST_TX, 32'(s.first_tx));
    write_reg(cbts_pkg::REG_SECOND_TX, 32'(s.second_tx));
    write_reg(cbts_pkg::REG_RD_COUNT, 32'(s.rd_count));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_now = s;
    setups_done++;
  endtask

  always @(posedge clk_i) begin : result_check
    response_t         want;
    cbts_pkg::result_t got;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= ready_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got = cbts_pkg::result_t'(m_axis_tdata[60:0]);
        responses_seen++;
        if (pending_responses.size() == 0) begin
          $error("result with nothing expected: tdata %h, tuser %h", m_axis_tdata, m_axis_tuser);
          failures++;
        end else begin
          want = pending_responses.pop_front();
          check_field("tx_valid", 16'(want.res.tx_valid), 16'(got.tx_valid));
          check_field("tx_byte", 16'(want.res.tx_byte), 16'(got.tx_byte));
          check_field("clear_start", 16'(want.res.clear_start), 16'(got.clear_start));
          check_field("stop_request", 16'(want.res.stop_request), 16'(got.stop_request));
          check_field("ack_control", 16'(want.res.ack_control), 16'(got.ack_control));
          check_field("frame_kind", 16'(want.frame_kind), 16'(m_axis_tuser));
          check_field("value_first", want.res.value_first, got.value_first);
          check_field("value_second", want.res.value_second, got.value_second);
          check_field("value_third", want.res.value_third, got.value_third);
          if (want.frame_kind inside {cbts_pkg::FRAME_RAW, cbts_pkg::FRAME_HPR}) frames_seen++;
        end
      end
    end
  end

  initial begin : watchdog
    #400_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan[$];
    settings_t s;
    int        target;
    int        pick;
    int        wait_cycles;
    cfg_now = '{8'h00, 2'd1, 8'h00, 8'h00, 3'd6};
    wr_pos  = '0;
    rd_pos  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(checked_row(cbts_pkg::EV_START, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b0,
                               cbts_pkg::ACK_KEEP));
    plan.push_back(checked_row(cbts_pkg::EV_RESTART, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0,
                               cbts_pkg::ACK_KEEP));
    plan.push_back(checked_row(cbts_pkg::EV_SLA_W_ACK, 8'h5A, 1'b1, 8'h00, 1'b0, 1'b0,
                               cbts_pkg::ACK_KEEP));
    plan.push_back(checked_row(cbts_pkg::EV_DATA_ACK, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
                               cbts_pkg::ACK_KEEP));
    plan.push_back(checked_row(cbts_pkg::EV_SLA_R_ACK, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0,
                               cbts_pkg::ACK_ACK));
    plan.push_back(event_row(cbts_pkg::EV_RX_ACK, 8'hFF));
    plan.push_back(event_row(cbts_pkg::EV_RX_ACK, 8'h00));
    plan.push_back(event_row(cbts_pkg::EV_RX_ACK, 8'h80));
    plan.push_back(event_row(cbts_pkg::EV_RX_ACK, 8'h7F));
    plan.push_back(event_row(cbts_pkg::EV_RX_ACK, 8'h01));
    plan.push_back(event_row(cbts_pkg::EV_RX_NACK, 8'hFE));
    plan.push_back(event_row(cbts_pkg::EV_RX_NACK, 8'hAA));
    plan.push_back(checked_row(8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, cbts_pkg::ACK_KEEP));
    plan.push_back(checked_row(8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, cbts_pkg::ACK_KEEP));
    plan.push_back(setup_row(cbts_pkg::ADDR_RAW, 2'd2, 8'hA5, 8'h5A, 3'd1));
    plan.push_back(checked_row(cbts_pkg::EV_START, 8'h00, 1'b1, cbts_pkg::ADDR_RAW, 1'b1, 1'b0,
                               cbts_pkg::ACK_KEEP));
    plan.push_back(event_row(cbts_pkg::EV_SLA_W_ACK, 8'h00));
    plan.push_back(event_row(cbts_pkg::EV_DATA_NACK, 8'h00));
    plan.push_back(event_row(cbts_pkg::EV_DATA_ACK, 8'h00));
    plan.push_back(event_row(cbts_pkg::EV_SLA_W_ACK, 8'h00));
    plan.push_back(event_row(cbts_pkg::EV_RX_ACK, 8'h12));
    plan.push_back(event_row(cbts_pkg::EV_RX_NACK, 8'h34));
    plan.push_back(setup_row(cbts_pkg::ADDR_HPR, 2'd3, 8'hFF, 8'h00, 3'd0));
    plan.push_back(event_row(cbts_pkg::EV_SLA_W_ACK, 8'h00));
    plan.push_back(event_row(cbts_pkg::EV_DATA_ACK, 8'h00));
    plan.push_back(event_row(cbts_pkg::EV_DATA_ACK, 8'h00));
    plan.push_back(event_row(cbts_pkg::EV_DATA_ACK, 8'h00));
    plan.push_back(event_row(cbts_pkg::EV_RX_ACK, 8'hC3));

    send_idle_pct  = 28;
    ready_idle_pct = 64;
    foreach (plan[i]) begin
      if (plan[i].is_setup) apply_settings(plan[i].cfg);
      else send_event(plan[i].command, plan[i].rx_byte, plan[i].typed, plan[i].want);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct  = 28;
          ready_idle_pct = 64;
        end
        1: begin
          send_idle_pct  = 64;
          ready_idle_pct = 28;
        end
        default: begin
          send_idle_pct  = 0;
          ready_idle_pct = 0;
        end
      endcase
      s = '{8'($urandom_range(255)), 2'($urandom_range(3)), 8'($urandom_range(255)),
            8'($urandom_range(255)), 3'($urandom_range(7))};
      case (seg)
        0: s = '{cbts_pkg::ADDR_RAW, 2'd0, 8'hFF, 8'h00, 3'd7};
        1: s = '{cbts_pkg::ADDR_HPR, 2'd3, 8'h00, 8'hFF, 3'd0};
        2: s = '{8'hFF, 2'd2, s.first_tx, s.second_tx, 3'd1};
        3: s = '{8'h00, 2'd1, s.first_tx, s.second_tx, 3'd6};
        default:
          if ($urandom_range(3) != 0)
            s.address = $urandom_range(1) ? cbts_pkg::ADDR_RAW : cbts_pkg::ADDR_HPR;
      endcase
      apply_settings(s);
      target = bus_events + ITEMS_PER_SEGMENT;
      while (bus_events < target) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          send_event(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);
        end else begin
          if (pick < 60) begin
            send_step(cbts_pkg::EV_START);
            send_step(cbts_pkg::EV_SLA_W_ACK);
            repeat ($urandom_range(4, 1))
              send_step($urandom_range(1) ? cbts_pkg::EV_DATA_ACK : cbts_pkg::EV_DATA_NACK);
          end
          if (pick >= 35) begin
            send_step(pick < 60 ? cbts_pkg::EV_RESTART : cbts_pkg::EV_START);
            send_step(cbts_pkg::EV_SLA_R_ACK);
            repeat ($urandom_range(9, 1))
              send_step($urandom_range(3) == 0 ? cbts_pkg::EV_RX_NACK : cbts_pkg::EV_RX_ACK);
          end
        end
        if ($urandom_range(49) == 0) drain_responses();
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_responses.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      $error("%0d expected results never arrived", pending_responses.size());
      failures++;
    end
    $display("Ran %0d bus events and checked %0d results over %0d register settings.",
             bus_events, responses_seen, setups_done);
    $display("%0d results carried decoded compass frames; three stall patterns were used.",
             frames_seen);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
